/* rtl/pps_pkg.sv */
// Shared types, request codes and priority arithmetic for the process priority scheduler.
`default_nettype none

package pps_pkg;

    // request codes
    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_SLEEP  = 3'd1;
    localparam logic [2:0] REQ_WAKEUP = 3'd2;
    localparam logic [2:0] REQ_DECAY  = 3'd3;
    localparam logic [2:0] REQ_SWITCH = 3'd4;
    localparam logic [2:0] REQ_SETPRI = 3'd5;

    localparam logic signed [7:0] PRIO_MAX  = 8'sd127;
    localparam logic signed [7:0] PRIO_MIN  = -8'sd126;
    localparam logic signed [7:0] BASE_INIT = 8'sd100;

    // one slot of the table
    typedef struct packed {
        logic [31:0]        chan;
        logic signed [7:0]  prio;
        logic [7:0]         cpu;
        logic signed [6:0]  nice;
    } t_entry;

    typedef enum logic [1:0] {
        SRC_CUR,
        SRC_REQ,
        SRC_SCAN
    } t_rd_src;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        t_rd_src rd_src;
        logic    cap_cur;
        logic    one;
        logic    scan_proc;
        logic    sel_commit;
        logic    resp;
    } t_cmd;

    typedef struct packed {
        logic scan_first;
        logic scan_last;
        logic out_free;
    } t_stat;

    // cpu/16 + base + nice, clamped to the legal priority range
    function automatic logic signed [7:0] f_recompute(
        input logic [7:0]        cpu,
        input logic signed [7:0] base,
        input logic signed [6:0] nice
    );
        logic signed [9:0] sum;
        sum = $signed({6'd0, cpu[7:4]}) + $signed({{2{base[7]}}, base})
            + $signed({{3{nice[6]}}, nice});
        if (sum >= 10'sd127) begin
            f_recompute = PRIO_MAX;
        end else if (sum <= -10'sd126) begin
            f_recompute = PRIO_MIN;
        end else begin
            f_recompute = sum[7:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/process_priority_scheduler_top.sv */
// Top level of the process priority scheduler: sequencer plus slot-table datapath.
//
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready) with their
//   fields on i_req_type, i_slot, i_chan, i_prio, i_nice_value, i_cpu_usage,
//   i_present and i_runnable. Each request yields one status item on the
//   output channel (o_out_valid / i_out_ready).
//   i_cfg_we / i_cfg_data write the user base priority; write it only while
//   no request is in flight.
//   The scans walk the slot table one entry per cycle through its single
//   read port, so one request is worked on at a time.
//   A new request is taken while a finished result still waits in the output
//   register; if the receiver keeps stalling, the next result waits inside
//   the block and no further request is taken.
//   Reset clears the table to empty slots, running slot 0, reschedule flag 0
//   and base priority 100; there is no clearing pass.
`default_nettype none

module process_priority_scheduler_top #(
    parameter int NUM_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic signed [7:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_req_type,
    input  logic [5:0]        i_slot,
    input  logic [31:0]       i_chan,
    input  logic signed [7:0] i_prio,
    input  logic signed [6:0] i_nice_value,
    input  logic [7:0]        i_cpu_usage,
    input  logic              i_present,
    input  logic              i_runnable,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [5:0]        o_current_slot,
    output logic              o_switched,
    output logic              o_resched,
    output logic [6:0]        o_woke_count
);
    import pps_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pps_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_chan         (i_chan),
        .i_prio         (i_prio),
        .i_nice_value   (i_nice_value),
        .i_cpu_usage    (i_cpu_usage),
        .i_present      (i_present),
        .i_runnable     (i_runnable),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_current_slot (o_current_slot),
        .o_switched     (o_switched),
        .o_resched      (o_resched),
        .o_woke_count   (o_woke_count)
    );

endmodule

`default_nettype wire

/* rtl/pps_datapath.sv */
// Slot table, scan datapath, selection and result register of the scheduler.
`default_nettype none

module pps_datapath #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pps_pkg::t_cmd           i_cmd,
    output pps_pkg::t_stat          o_stat,
    input  logic                    i_cfg_we,
    input  logic signed [7:0]       i_cfg_data,
    input  logic [2:0]              i_req_type,
    input  logic [5:0]              i_slot,
    input  logic [31:0]             i_chan,
    input  logic signed [7:0]       i_prio,
    input  logic signed [6:0]       i_nice_value,
    input  logic [7:0]              i_cpu_usage,
    input  logic                    i_present,
    input  logic                    i_runnable,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [5:0]              o_current_slot,
    output logic                    o_switched,
    output logic                    o_resched,
    output logic [6:0]              o_woke_count
);
    import pps_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

    // latched item
    logic [2:0]         r_req;
    logic [AW-1:0]      r_slot_addr;
    logic               r_slot_ok;
    logic [31:0]        r_chan;
    logic signed [7:0]  r_prio;
    logic signed [6:0]  r_nice;
    logic [7:0]         r_cpu;
    logic               r_present_in;
    logic               r_runnable_in;

    logic signed [7:0]  r_base;
    logic [NUM_SLOTS-1:0] r_present;
    logic [NUM_SLOTS-1:0] r_runnable;
    logic [NUM_SLOTS-1:0] r_valid;
    t_entry             r_mem [NUM_SLOTS];

    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_pend_idx;
    logic [AW-1:0]      r_scan_idx;

    logic [5:0]         r_running;
    logic               r_resched;
    logic signed [7:0]  r_cur_prio;
    logic signed [7:0]  r_best;
    logic [AW-1:0]      r_pick;
    logic               r_switched;
    logic [CW-1:0]      r_woke;

    logic               r_out_valid;
    logic [5:0]         r_out_slot;
    logic               r_out_switched;
    logic               r_out_resched;
    logic [6:0]         r_out_woke;

    logic [AW+5:0]      slot_wide;
    logic [AW+5:0]      run_wide;
    logic [AW+5:0]      pick_wide;
    logic [CW+6:0]      woke_wide;
    logic [AW-1:0]      cur_addr;
    logic [5:0]         pick6;
    logic [AW-1:0]      rd_addr;
    t_entry             e;
    logic [7:0]         cpu_half;
    logic [7:0]         rc_cpu;
    logic signed [7:0]  rc_prio;
    logic               pend_is_cur;
    logic               pend_present;
    logic               pend_run;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_entry;
    logic               resched_set;
    logic               cur_upd;
    logic               wake;
    logic               sel_hit;

    assign slot_wide = {{AW{1'b0}}, i_slot};
    assign run_wide  = {{AW{1'b0}}, r_running};
    assign pick_wide = {6'd0, r_pick};
    assign woke_wide = {7'd0, r_woke};
    assign cur_addr  = run_wide[AW-1:0];
    assign pick6     = pick_wide[5:0];

    always_comb begin
        case (i_cmd.rd_src)
            SRC_CUR: rd_addr = cur_addr;
            SRC_REQ: rd_addr = r_slot_addr;
            default: rd_addr = r_scan_idx;
        endcase
    end

    // an entry never written reads as zero
    assign e            = r_rd_vld ? r_rd_data : '0;
    assign cpu_half     = e.cpu >> 1;
    assign rc_cpu       = (r_req == REQ_DECAY) ? cpu_half : e.cpu;
    assign rc_prio      = f_recompute(rc_cpu, r_base, e.nice);
    assign pend_is_cur  = (r_pend_idx == cur_addr);
    assign pend_present = r_present[r_pend_idx];
    assign pend_run     = r_runnable[r_pend_idx];

    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = r_pend_idx;
        wr_entry    = e;
        resched_set = 1'b0;
        cur_upd     = 1'b0;
        wake        = 1'b0;
        sel_hit     = 1'b0;
        if (i_cmd.one) begin
            case (r_req)
                REQ_LOAD: begin
                    wr_en          = r_slot_ok;
                    wr_addr        = r_slot_addr;
                    wr_entry.chan  = '0;
                    wr_entry.prio  = r_prio;
                    wr_entry.cpu   = r_cpu;
                    wr_entry.nice  = r_nice;
                end
                REQ_SLEEP: begin
                    wr_en         = 1'b1;
                    wr_addr       = cur_addr;
                    wr_entry.chan = r_chan;
                    wr_entry.prio = r_prio;
                end
                REQ_SETPRI: begin
                    wr_en         = r_slot_ok;
                    wr_entry.prio = rc_prio;
                    resched_set   = r_slot_ok && !pend_is_cur && (e.prio < r_cur_prio);
                end
                default: ;
            endcase
        end else if (i_cmd.scan_proc) begin
            case (r_req)
                REQ_WAKEUP: begin
                    if (pend_present && (e.chan == r_chan)) begin
                        wr_en         = 1'b1;
                        wr_entry.chan = '0;
                        wake          = 1'b1;
                    end
                end
                REQ_DECAY: begin
                    if (pend_present) begin
                        wr_en        = 1'b1;
                        wr_entry.cpu = cpu_half;
                        if (e.prio > r_base) begin
                            wr_entry.prio = rc_prio;
                            resched_set   = !pend_is_cur && (e.prio < r_cur_prio);
                            cur_upd       = pend_is_cur;
                        end
                    end
                end
                default: begin
                    sel_hit = pend_present && pend_run && (e.prio <= r_best);
                end
            endcase
        end
    end

    // table storage, no reset: the valid bits stand in for it
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_pend_idx <= rd_addr;
        end
        if (i_cmd.latch) begin
            r_req         <= i_req_type;
            r_slot_addr   <= slot_wide[AW-1:0];
            r_slot_ok     <= slot_wide < (AW+6)'(NUM_SLOTS);
            r_chan        <= i_chan;
            r_prio        <= i_prio;
            r_nice        <= i_nice_value;
            r_cpu         <= i_cpu_usage;
            r_present_in  <= i_present;
            r_runnable_in <= i_runnable;
        end
        if (i_cmd.cap_cur) begin
            r_cur_prio <= e.prio;
        end else if (cur_upd) begin
            r_cur_prio <= rc_prio;
        end
        if (i_cmd.latch) begin
            r_best <= PRIO_MAX;
            r_pick <= '0;
        end else if (sel_hit) begin
            r_best <= e.prio;
            r_pick <= r_pend_idx;
        end
        if (i_cmd.resp) begin
            r_out_slot     <= r_running;
            r_out_switched <= r_switched;
            r_out_resched  <= r_resched;
            r_out_woke     <= woke_wide[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_INIT;
            r_present   <= '0;
            r_runnable  <= '0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_scan_idx  <= '0;
            r_running   <= '0;
            r_resched   <= 1'b0;
            r_switched  <= 1'b0;
            r_woke      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.one && (r_req == REQ_LOAD) && r_slot_ok) begin
                r_present[r_slot_addr]  <= r_present_in;
                r_runnable[r_slot_addr] <= r_runnable_in;
            end
            if (i_cmd.one && (r_req == REQ_SLEEP)) begin
                r_runnable[cur_addr] <= 1'b0;
            end
            if (wake) begin
                r_runnable[r_pend_idx] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (i_cmd.latch) begin
                r_scan_idx <= '0;
            end else if (i_cmd.rd_en && (i_cmd.rd_src == SRC_SCAN)) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (i_cmd.sel_commit) begin
                r_resched <= 1'b0;
            end else if (resched_set) begin
                r_resched <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_switched <= 1'b0;
            end else if (i_cmd.sel_commit) begin
                r_switched <= (pick6 != r_running);
            end
            if (i_cmd.sel_commit) begin
                r_running <= pick6;
            end
            if (i_cmd.latch) begin
                r_woke <= '0;
            end else if (wake) begin
                r_woke <= r_woke + 1'b1;
            end
            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.scan_first = (r_scan_idx == '0);
    assign o_stat.scan_last  = (r_scan_idx == LAST_IDX);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_current_slot = r_out_slot;
    assign o_switched     = r_out_switched;
    assign o_resched      = r_out_resched;
    assign o_woke_count   = r_out_woke;

`ifndef SYNTHESIS
    a_commit_clears_resched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sel_commit |=> !r_resched)
        else $error("reschedule flag not cleared by selection");

    a_commit_picks_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sel_commit |=> (r_running == '0)
            || (r_present[cur_addr] && r_runnable[cur_addr]))
        else $error("selected slot is neither fallback nor runnable");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(wr_addr)])
        else $error("written slot not marked valid");
`endif

endmodule

`default_nettype wire

/* rtl/pps_ctrl.sv */
// Request sequencer of the scheduler: issues table reads, scans and the result.
`default_nettype none

module pps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [2:0]      i_req_type,
    input  pps_pkg::t_stat  i_stat,
    output pps_pkg::t_cmd   o_cmd
);
    import pps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CUR,
        S_CAP_CUR,
        S_ONE,
        S_SCAN,
        S_TAIL,
        S_SEL,
        S_RESP
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_req;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        o_cmd.rd_src = SRC_SCAN;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_req_type) inside
                        REQ_LOAD:                          n_state = S_ONE;
                        REQ_SLEEP, REQ_DECAY, REQ_SETPRI:  n_state = S_RD_CUR;
                        REQ_WAKEUP, REQ_SWITCH:            n_state = S_SCAN;
                        default:                           n_state = S_RESP;
                    endcase
                end
            end
            S_RD_CUR: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = SRC_CUR;
                n_state = (r_req == REQ_SLEEP) ? S_ONE : S_CAP_CUR;
            end
            S_CAP_CUR: begin
                o_cmd.cap_cur = 1'b1;
                if (r_req == REQ_SETPRI) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_REQ;
                    n_state = S_ONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ONE: begin
                o_cmd.one = 1'b1;
                n_state = (r_req == REQ_SLEEP) ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                // read the next slot while the previous one is processed
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_src    = SRC_SCAN;
                o_cmd.scan_proc = !i_stat.scan_first;
                if (i_stat.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.scan_proc = 1'b1;
                n_state = ((r_req == REQ_SLEEP) || (r_req == REQ_SWITCH)) ? S_SEL : S_RESP;
            end
            S_SEL: begin
                o_cmd.sel_commit = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_LOAD;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_req <= i_req_type;
            end
        end
    end

`ifndef SYNTHESIS
    a_scan_ends_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_stat.scan_last |=> (r_state == S_TAIL))
        else $error("scan did not stop after the last slot");

    a_select_only_for_switching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (r_req == REQ_SLEEP) || (r_req == REQ_SWITCH))
        else $error("selection committed for a request that does not select");
`endif

endmodule

`default_nettype wire

/* verif/pps_status_checker.sv */
// Scoreboard for the process priority scheduler: tracks the slot table, checks status items.
module pps_status_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic signed [7:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [2:0]        i_req_type,
    input  logic [5:0]        i_slot,
    input  logic [31:0]       i_chan,
    input  logic signed [7:0] i_prio,
    input  logic signed [6:0] i_nice_value,
    input  logic [7:0]        i_cpu_usage,
    input  logic              i_present,
    input  logic              i_runnable,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [5:0]        i_current_slot,
    input  logic              i_switched,
    input  logic              i_resched,
    input  logic [6:0]        i_woke_count,
    output int                o_fail_count,
    output int                o_waiting,
    output int                o_checked,
    output int                o_switches,
    output int                o_woken
);
    import pps_pkg::*;

    localparam int SLOTS = 64;

    typedef struct packed {
        logic [5:0] cur;
        logic       sw;
        logic       rs;
        logic [6:0] woke;
    } t_status;

    logic              tbl_present [SLOTS];
    logic              tbl_runnable[SLOTS];
    logic [31:0]       tbl_chan    [SLOTS];
    logic signed [7:0] tbl_prio    [SLOTS];
    logic [7:0]        tbl_cpu     [SLOTS];
    logic signed [6:0] tbl_nice    [SLOTS];
    logic [5:0]        run_slot;
    logic              resched;
    logic signed [7:0] base_prio;
    t_status           status_q[$];
    int                fails    = 0;
    int                checked  = 0;
    int                switches = 0;
    int                woken    = 0;

    function automatic void clear_table();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            tbl_present[i]  = 1'b0;
            tbl_runnable[i] = 1'b0;
            tbl_chan[i]     = '0;
            tbl_prio[i]     = '0;
            tbl_cpu[i]      = '0;
            tbl_nice[i]     = '0;
        end
        run_slot  = '0;
        resched   = 1'b0;
        base_prio = BASE_INIT;
    endfunction

    // cpu/16 + base + nice, clamped; flag a reschedule against the old priority
    function automatic void reprioritise(input int s);
        int n;
        n = int'(tbl_cpu[s] >> 4) + int'(base_prio) + int'(tbl_nice[s]);
        if (n > 127) n = 127;
        if (n < -126) n = -126;
        if (s != int'(run_slot) && tbl_prio[s] < tbl_prio[run_slot]) resched = 1'b1;
        tbl_prio[s] = n[7:0];
    endfunction

    // lowest priority wins, ties to the higher index, slot 0 when nothing is runnable
    function automatic logic pick_next();
        logic signed [7:0] best;
        logic [5:0]        pick;
        logic [5:0]        prev;
        int                i;
        best    = PRIO_MAX;
        pick    = '0;
        prev    = run_slot;
        resched = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            if (tbl_present[i] && tbl_runnable[i] && tbl_prio[i] <= best) begin
                best = tbl_prio[i];
                pick = i[5:0];
            end
        end
        run_slot = pick;
        return pick != prev;
    endfunction

    function automatic t_status apply_request(
        input logic [2:0]        kind,
        input logic [5:0]        slot,
        input logic [31:0]       chan,
        input logic signed [7:0] prio,
        input logic signed [6:0] nice,
        input logic [7:0]        cpu,
        input logic              present,
        input logic              runnable
    );
        t_status st;
        int      woke;
        logic    sw;
        int      i;
        woke = 0;
        sw   = 1'b0;
        case (kind)
            REQ_LOAD: begin
                tbl_present[slot]  = present;
                tbl_runnable[slot] = runnable;
                tbl_chan[slot]     = '0;
                tbl_prio[slot]     = prio;
                tbl_nice[slot]     = nice;
                tbl_cpu[slot]      = cpu;
            end
            REQ_SLEEP: begin
                tbl_chan[run_slot]     = chan;
                tbl_prio[run_slot]     = prio;
                tbl_runnable[run_slot] = 1'b0;
                sw = pick_next();
            end
            REQ_WAKEUP: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_present[i] && tbl_chan[i] == chan) begin
                        tbl_chan[i]     = '0;
                        tbl_runnable[i] = 1'b1;
                        woke++;
                    end
                end
            end
            REQ_DECAY: begin
                // scan in index order: the running slot's priority may change mid-scan
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_present[i]) begin
                        tbl_cpu[i] = tbl_cpu[i] >> 1;
                        if (tbl_prio[i] > base_prio) reprioritise(i);
                    end
                end
            end
            REQ_SWITCH: sw = pick_next();
            REQ_SETPRI: reprioritise(int'(slot));
            default: ;
        endcase
        st.cur  = run_slot;
        st.sw   = sw;
        st.rs   = resched;
        st.woke = woke[6:0];
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] status mismatch: %s", $time, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_status want;
        if (!i_rst_n) begin
            clear_table();
            status_q.delete();
        end else begin
            if (i_cfg_we) base_prio = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("status item with none outstanding (slot %0d)",
                                              i_current_slot));
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    if (i_current_slot !== want.cur)
                        report_mismatch($sformatf("current_slot got %0d want %0d",
                                                  i_current_slot, want.cur));
                    if (i_switched !== want.sw)
                        report_mismatch($sformatf("switched got %b want %b",
                                                  i_switched, want.sw));
                    if (i_resched !== want.rs)
                        report_mismatch($sformatf("resched got %b want %b",
                                                  i_resched, want.rs));
                    if (i_woke_count !== want.woke)
                        report_mismatch($sformatf("woke_count got %0d want %0d",
                                                  i_woke_count, want.woke));
                    if (want.sw) switches++;
                    woken += int'(want.woke);
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(apply_request(i_req_type, i_slot, i_chan, i_prio,
                                                 i_nice_value, i_cpu_usage, i_present,
                                                 i_runnable));
        end
        o_waiting    <= status_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_switches   <= switches;
        o_woken      <= woken;
    end

endmodule

/* verif/tb_process_priority_scheduler_top.sv */
// Testbench top for the process priority scheduler: clock, reset, request stimulus and verdict.
module tb_process_priority_scheduler_top;
    import pps_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          SEGMENTS       = 6;
    localparam int          SEG_ITEMS      = 180;
    localparam logic [2:0]  REQ_SPARE_LO   = 3'd6;
    localparam logic [2:0]  REQ_SPARE_HI   = 3'd7;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic signed [7:0] cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic [2:0]        req_type     = '0;
    logic [5:0]        req_slot     = '0;
    logic [31:0]       req_chan     = '0;
    logic signed [7:0] req_prio     = '0;
    logic signed [6:0] req_nice     = '0;
    logic [7:0]        req_cpu      = '0;
    logic              req_present  = 1'b0;
    logic              req_runnable = 1'b0;
    logic              out_ready    = 1'b0;
    wire               in_ready;
    wire               out_valid;
    wire  [5:0]        cur_slot;
    wire               switched;
    wire               resched;
    wire  [6:0]        woke_count;

    int fail_count;
    int n_waiting;
    int n_checked;
    int n_switches;
    int n_woken;

    int snd_idle_pct = 32;
    int rx_idle_pct  = 72;
    int n_sent       = 0;
    int n_bases      = 1;
    int quiet        = 0;

    logic [31:0]       chan_pool [4];
    logic signed [7:0] base_plan [SEGMENTS] = '{PRIO_MIN, PRIO_MAX, 8'sd40, 8'sd0,
                                                -8'sd60, BASE_INIT};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    process_priority_scheduler_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_slot         (req_slot),
        .i_chan         (req_chan),
        .i_prio         (req_prio),
        .i_nice_value   (req_nice),
        .i_cpu_usage    (req_cpu),
        .i_present      (req_present),
        .i_runnable     (req_runnable),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_current_slot (cur_slot),
        .o_switched     (switched),
        .o_resched      (resched),
        .o_woke_count   (woke_count)
    );

    pps_status_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_slot         (req_slot),
        .i_chan         (req_chan),
        .i_prio         (req_prio),
        .i_nice_value   (req_nice),
        .i_cpu_usage    (req_cpu),
        .i_present      (req_present),
        .i_runnable     (req_runnable),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_current_slot (cur_slot),
        .i_switched     (switched),
        .i_resched      (resched),
        .i_woke_count   (woke_count),
        .o_fail_count   (fail_count),
        .o_waiting      (n_waiting),
        .o_checked      (n_checked),
        .o_switches     (n_switches),
        .o_woken        (n_woken)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // end the run when no item moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles, %0d results outstanding",
                     quiet, n_waiting);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_req(
        input logic [2:0]        kind,
        input logic [5:0]        slot,
        input logic [31:0]       chan,
        input logic signed [7:0] prio,
        input logic signed [6:0] nice,
        input logic [7:0]        cpu,
        input logic              present,
        input logic              runnable
    );
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        req_slot     <= slot;
        req_chan     <= chan;
        req_prio     <= prio;
        req_nice     <= nice;
        req_cpu      <= cpu;
        req_present  <= present;
        req_runnable <= runnable;
        // hold until the item is taken
        do @(posedge clk); while (!in_ready);
        n_sent++;
    endtask

    task automatic send_random();
        logic [2:0]  kind;
        logic [5:0]  slot;
        logic [31:0] chan;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 28)      kind = REQ_LOAD;
        else if (roll < 40) kind = REQ_SLEEP;
        else if (roll < 54) kind = REQ_WAKEUP;
        else if (roll < 64) kind = REQ_DECAY;
        else if (roll < 80) kind = REQ_SWITCH;
        else if (roll < 94) kind = REQ_SETPRI;
        else                kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        // keep most traffic on a few slots and channels so sleeps meet wakeups
        slot = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(11));
        chan = ($urandom_range(6) == 0) ? $urandom() : chan_pool[$urandom_range(3)];
        send_req(kind, slot, chan, 8'($urandom), 7'($urandom), 8'($urandom),
                 $urandom_range(7) != 0, 1'($urandom));
    endtask

    task automatic set_base(input logic signed [7:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (n_waiting != 0);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_bases++;
    endtask

    initial begin : stimulus
        int seg;
        int k;
        chan_pool[0] = '0;
        chan_pool[1] = 32'hFFFF_FFFF;
        chan_pool[2] = $urandom();
        chan_pool[3] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, fallback to slot 0, extremes, spare codes, clamping
        send_req(REQ_SWITCH, 6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SLEEP,  6'd0,  32'hFFFF_FFFF, 8'sd127, 7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_LOAD,   6'd63, '0,           -8'sd128, -7'sd64, 8'd255, 1'b1, 1'b1);
        send_req(REQ_LOAD,   6'd0,  '0,           8'sd127,  7'sd63,  8'd0,   1'b1, 1'b1);
        send_req(REQ_LOAD,   6'd5,  '0,           8'sd127,  7'sd0,   8'd200, 1'b1, 1'b1);
        send_req(REQ_LOAD,   6'd7,  '0,           -8'sd126, 7'sd0,   8'd16,  1'b0, 1'b1);
        send_req(REQ_LOAD,   6'd9,  '0,           -8'sd127, 7'sd5,   8'd100, 1'b1, 1'b0);
        send_req(REQ_SWITCH, 6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SLEEP,  6'd0,  32'hFFFF_FFFF, -8'sd127, 7'sd0,  8'd0,   1'b0, 1'b0);
        send_req(REQ_SPARE_LO, 6'd63, '1,         -8'sd1,   -7'sd1,  8'd255, 1'b1, 1'b1);
        send_req(REQ_SPARE_HI, 6'd0,  '0,         8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SETPRI, 6'd63, '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_WAKEUP, 6'd0,  32'hFFFF_FFFF, 8'sd0,   7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_WAKEUP, 6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_DECAY,  6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SWITCH, 6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_LOAD,   6'd10, '0,           8'sd127,  7'sd63,  8'd255, 1'b1, 1'b1);
        send_req(REQ_SETPRI, 6'd10, '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_LOAD,   6'd63, '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SETPRI, 6'd7,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_DECAY,  6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_SWITCH, 6'd0,  '0,           8'sd0,    7'sd0,   8'd0,   1'b0, 1'b0);
        send_req(REQ_WAKEUP, 6'd0,  32'h1234_5678, 8'sd0,   7'sd0,   8'd0,   1'b0, 1'b0);

        // random: two base settings per pacing mode
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin snd_idle_pct = 32; rx_idle_pct = 72; end
                1: begin snd_idle_pct = 72; rx_idle_pct = 32; end
                default: begin snd_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            set_base(base_plan[seg]);
            for (k = 0; k < SEG_ITEMS; k++) send_random();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (n_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests across %0d base priority settings and three pacing modes.",
                 n_sent, n_bases);
        $display("%0d status items compared, %0d selections moved the running slot, %0d slots woken.",
                 n_checked, n_switches, n_woken);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
